// ===== src/alfl_pkg.sv =====
package alfl_pkg;

   localparam int DEPTH_DEF = 64;
   localparam int CMD_W     = 3;
   localparam int IDX_W     = 6;
   localparam int KEY_W     = 64;
   localparam int STATUS_W  = 2;
   localparam int COUNT_W   = 7;

   typedef enum logic [CMD_W-1:0] {
      CMD_APPEND = 3'd0,
      CMD_FIND   = 3'd1,
      CMD_REMOVE = 3'd2,
      CMD_READ   = 3'd3,
      CMD_WRITE  = 3'd4,
      CMD_CLEAR  = 3'd5
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK   = 2'd0,
      ST_FULL = 2'd1,
      ST_MISS = 2'd2
   } status_type;

endpackage

// ===== src/alfl_req_if.sv =====
interface alfl_req_if;
   import alfl_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [IDX_W-1:0]   slot_index;
   logic [KEY_W-1:0]   entry_key;

   modport source (output valid, command, slot_index, entry_key, input ready);
   modport sink   (input valid, command, slot_index, entry_key, output ready);

endinterface

// ===== src/alfl_rsp_if.sv =====
interface alfl_rsp_if;
   import alfl_pkg::*;

   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [IDX_W-1:0]    result_index;
   logic [KEY_W-1:0]    read_key;
   logic [COUNT_W-1:0]  entry_count;

   modport source (output valid, status, result_index, read_key, entry_count, input ready);
   modport sink   (input valid, status, result_index, read_key, entry_count, output ready);

endinterface

// ===== src/array_linked_list_with_free_list_core.sv =====
// Write, unused codes, full store or early miss go from idle straight to staging (S_PUT); read,
// append to an empty list and head remove first pass their RAM read state (S_RDKEY, S_ALLOC,
// S_RMHEAD); append walks in S_TAIL, find in S_FIND, remove in S_RMWALK, S_RMLINK, S_RMFREE
// (one linked node per cycle via the RAM read port); clear sweeps every node. One item at a
// time; a result not yet taken holds the next one in staging. Reset (synchronous): a pass
// zeroes the keys and chains every node onto the free list; no beat is accepted until it ends.
module array_linked_list_with_free_list_core #(
   parameter int DEPTH = alfl_pkg::DEPTH_DEF
) (
   input  logic       clock,
   input  logic       reset,
   alfl_req_if.sink   req,
   alfl_rsp_if.source rsp
);
   import alfl_pkg::*;

   localparam int AW = $clog2(DEPTH);
   localparam int NW = AW + 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [NW-1:0] NIL       = NW'(DEPTH);
   localparam logic [CW-1:0] STEP_MAX  = CW'(DEPTH);
   localparam logic [AW-1:0] SWEEP_END = AW'(DEPTH - 1);

   typedef enum logic [11:0] {
      S_INIT   = 12'b0000_0000_0001,
      S_IDLE   = 12'b0000_0000_0010,
      S_ALLOC  = 12'b0000_0000_0100,
      S_TAIL   = 12'b0000_0000_1000,
      S_FIND   = 12'b0000_0001_0000,
      S_RMHEAD = 12'b0000_0010_0000,
      S_RMWALK = 12'b0000_0100_0000,
      S_RMLINK = 12'b0000_1000_0000,
      S_RMFREE = 12'b0001_0000_0000,
      S_RDKEY  = 12'b0010_0000_0000,
      S_CLEAR  = 12'b0100_0000_0000,
      S_PUT    = 12'b1000_0000_0000
   } state_type;

   function automatic logic is_node(input logic [NW-1:0] n);
      return n < NIL;
   endfunction

   state_type         state_ff, state_in;
   logic [NW-1:0]     list_head_ff, list_head_in;
   logic [NW-1:0]     free_head_ff, free_head_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [CW-1:0]     steps_ff, steps_in;
   logic [AW-1:0]     sweep_ff, sweep_in;
   logic [AW-1:0]     p_ff, p_in;
   logic [AW-1:0]     node_ff, node_in;
   logic [AW-1:0]     idx_ff, idx_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   status_type        status_ff, status_in;
   logic [AW-1:0]     res_idx_ff, res_idx_in;
   logic [KEY_W-1:0]  rkey_ff, rkey_in;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [IDX_W-1:0]    rsp_index_ff;
   logic [KEY_W-1:0]    rsp_key_ff;
   logic [COUNT_W-1:0]  rsp_count_ff;
   logic                load_rsp;

   logic [AW-1:0]    rd_addr;
   logic             key_we;
   logic [AW-1:0]    key_waddr;
   logic [KEY_W-1:0] key_wdata;
   logic [KEY_W-1:0] key_rdata;
   logic             link_we;
   logic [AW-1:0]    link_waddr;
   logic [NW-1:0]    link_wdata;
   logic [NW-1:0]    link_rdata;

   logic          slot_ok;
   logic [CW-1:0] steps_next;
   logic [NW-1:0] sweep_link;

   assign slot_ok    = 32'(req.slot_index) < DEPTH;
   assign steps_next = steps_ff + CW'(1);
   assign sweep_link = NW'(sweep_ff) + NW'(1);

   alfl_ram #(.WIDTH(KEY_W), .DEPTH(DEPTH)) u_key_ram (
      .clock (clock),
      .we    (key_we),
      .waddr (key_waddr),
      .wdata (key_wdata),
      .raddr (rd_addr),
      .rdata (key_rdata)
   );

   alfl_ram #(.WIDTH(NW), .DEPTH(DEPTH)) u_link_ram (
      .clock (clock),
      .we    (link_we),
      .waddr (link_waddr),
      .wdata (link_wdata),
      .raddr (rd_addr),
      .rdata (link_rdata)
   );

   always_comb begin
      state_in     = state_ff;
      list_head_in = list_head_ff;
      free_head_in = free_head_ff;
      count_in     = count_ff;
      steps_in     = steps_ff;
      sweep_in     = sweep_ff;
      p_in         = p_ff;
      node_in      = node_ff;
      idx_in       = idx_ff;
      key_in       = key_ff;
      status_in    = status_ff;
      res_idx_in   = res_idx_ff;
      rkey_in      = rkey_ff;
      load_rsp     = 1'b0;
      rd_addr      = p_ff;
      key_we       = 1'b0;
      key_waddr    = node_ff;
      key_wdata    = key_ff;
      link_we      = 1'b0;
      link_waddr   = p_ff;
      link_wdata   = NIL;

      unique case (state_ff)
         S_INIT: begin
            key_we     = 1'b1;
            key_waddr  = sweep_ff;
            key_wdata  = '0;
            link_we    = 1'b1;
            link_waddr = sweep_ff;
            link_wdata = sweep_link;
            sweep_in   = sweep_ff + AW'(1);
            if (sweep_ff == SWEEP_END) begin
               sweep_in = '0;
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req.valid) begin
               status_in  = ST_OK;
               res_idx_in = '0;
               rkey_in    = '0;
               key_in     = req.entry_key;
               idx_in     = AW'(req.slot_index);
               steps_in   = '0;
               state_in   = S_PUT;
               unique case (cmd_type'(req.command))
                  CMD_APPEND: begin
                     if (!is_node(free_head_ff)) begin
                        status_in = ST_FULL;
                     end else begin
                        rd_addr  = AW'(free_head_ff);
                        node_in  = AW'(free_head_ff);
                        state_in = S_ALLOC;
                     end
                  end
                  CMD_FIND: begin
                     status_in = ST_MISS;
                     if (is_node(list_head_ff)) begin
                        rd_addr  = AW'(list_head_ff);
                        p_in     = AW'(list_head_ff);
                        state_in = S_FIND;
                     end
                  end
                  CMD_REMOVE: begin
                     if (!is_node(list_head_ff) || !slot_ok) begin
                        status_in = ST_MISS;
                     end else if (list_head_ff == NW'(req.slot_index)) begin
                        rd_addr  = AW'(req.slot_index);
                        state_in = S_RMHEAD;
                     end else begin
                        rd_addr  = AW'(list_head_ff);
                        p_in     = AW'(list_head_ff);
                        state_in = S_RMWALK;
                     end
                  end
                  CMD_READ: begin
                     if (slot_ok) begin
                        rd_addr  = AW'(req.slot_index);
                        state_in = S_RDKEY;
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  CMD_WRITE: begin
                     if (slot_ok) begin
                        key_we    = 1'b1;
                        key_waddr = AW'(req.slot_index);
                        key_wdata = req.entry_key;
                     end else begin
                        status_in = ST_MISS;
                     end
                  end
                  CMD_CLEAR: begin
                     sweep_in = '0;
                     state_in = S_CLEAR;
                  end
                  default: begin
                     state_in = S_PUT;
                  end
               endcase
            end
         end
         S_ALLOC: begin
            free_head_in = link_rdata;
            key_we       = 1'b1;
            key_waddr    = node_ff;
            key_wdata    = key_ff;
            link_we      = 1'b1;
            link_waddr   = node_ff;
            link_wdata   = NIL;
            if (!is_node(list_head_ff)) begin
               list_head_in = NW'(node_ff);
               count_in     = count_ff + CW'(1);
               res_idx_in   = node_ff;
               state_in     = S_PUT;
            end else begin
               rd_addr  = AW'(list_head_ff);
               p_in     = AW'(list_head_ff);
               state_in = S_TAIL;
            end
         end
         S_TAIL: begin
            if (steps_ff < STEP_MAX && is_node(link_rdata)) begin
               rd_addr  = AW'(link_rdata);
               p_in     = AW'(link_rdata);
               steps_in = steps_next;
            end else begin
               link_we    = 1'b1;
               link_waddr = p_ff;
               link_wdata = NW'(node_ff);
               count_in   = count_ff + CW'(1);
               res_idx_in = node_ff;
               state_in   = S_PUT;
            end
         end
         S_FIND: begin
            if (key_rdata == key_ff) begin
               status_in  = ST_OK;
               res_idx_in = p_ff;
               state_in   = S_PUT;
            end else if (steps_next < STEP_MAX && is_node(link_rdata)) begin
               rd_addr  = AW'(link_rdata);
               p_in     = AW'(link_rdata);
               steps_in = steps_next;
            end else begin
               state_in = S_PUT;
            end
         end
         S_RMHEAD: begin
            list_head_in = link_rdata;
            link_we      = 1'b1;
            link_waddr   = idx_ff;
            link_wdata   = free_head_ff;
            free_head_in = NW'(idx_ff);
            count_in     = count_ff - CW'(1);
            state_in     = S_PUT;
         end
         S_RMWALK: begin
            if (link_rdata == NW'(idx_ff)) begin
               rd_addr  = idx_ff;
               state_in = S_RMLINK;
            end else if (steps_next < STEP_MAX && is_node(link_rdata)) begin
               rd_addr  = AW'(link_rdata);
               p_in     = AW'(link_rdata);
               steps_in = steps_next;
            end else begin
               status_in = ST_MISS;
               state_in  = S_PUT;
            end
         end
         S_RMLINK: begin
            link_we    = 1'b1;
            link_waddr = p_ff;
            link_wdata = link_rdata;
            state_in   = S_RMFREE;
         end
         S_RMFREE: begin
            link_we      = 1'b1;
            link_waddr   = idx_ff;
            link_wdata   = free_head_ff;
            free_head_in = NW'(idx_ff);
            count_in     = count_ff - CW'(1);
            state_in     = S_PUT;
         end
         S_RDKEY: begin
            rkey_in  = key_rdata;
            state_in = S_PUT;
         end
         S_CLEAR: begin
            link_we    = 1'b1;
            link_waddr = sweep_ff;
            link_wdata = sweep_link;
            sweep_in   = sweep_ff + AW'(1);
            if (sweep_ff == SWEEP_END) begin
               sweep_in     = '0;
               free_head_in = '0;
               list_head_in = NIL;
               count_in     = '0;
               state_in     = S_PUT;
            end
         end
         S_PUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               load_rsp = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load_rsp | (rsp_valid_ff & ~rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         list_head_ff <= NIL;
         free_head_ff <= '0;
         count_ff     <= '0;
         sweep_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         list_head_ff <= list_head_in;
         free_head_ff <= free_head_in;
         count_ff     <= count_in;
         sweep_ff     <= sweep_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      steps_ff   <= steps_in;
      p_ff       <= p_in;
      node_ff    <= node_in;
      idx_ff     <= idx_in;
      key_ff     <= key_in;
      status_ff  <= status_in;
      res_idx_ff <= res_idx_in;
      rkey_ff    <= rkey_in;
      if (load_rsp) begin
         rsp_status_ff <= status_ff;
         rsp_index_ff  <= IDX_W'(res_idx_ff);
         rsp_key_ff    <= rkey_ff;
         rsp_count_ff  <= COUNT_W'(count_ff);
      end
   end

   assign req.ready        = (state_ff == S_IDLE);
   assign rsp.valid        = rsp_valid_ff;
   assign rsp.status       = rsp_status_ff;
   assign rsp.result_index = rsp_index_ff;
   assign rsp.read_key     = rsp_key_ff;
   assign rsp.entry_count  = rsp_count_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= STEP_MAX)
      else $error("live count exceeds depth");

   a_head_vs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (is_node(list_head_ff) == (count_ff != '0)))
      else $error("list head disagrees with live count");

   a_free_vs_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE) |-> (!is_node(free_head_ff) == (count_ff == STEP_MAX)))
      else $error("free head disagrees with live count");

   a_put_loads: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_PUT && !rsp_valid_ff) |=> (rsp_valid_ff && state_ff == S_IDLE))
      else $error("staged result not moved to output");
`endif

endmodule

// ===== src/alfl_ram.sv =====
module alfl_ram #(
   parameter int WIDTH = alfl_pkg::KEY_W,
   parameter int DEPTH = alfl_pkg::DEPTH_DEF
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   import alfl_pkg::*;

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== verif/tb_top.sv =====
module tb_top;
   import alfl_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NODES = DEPTH_DEF;
   localparam logic [COUNT_W-1:0] NIL = COUNT_W'(NODES);
   localparam logic [CMD_W-1:0] CMD_SPARE_LO = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SPARE_HI = 3'd7;
   localparam logic [KEY_W-1:0] KEY_ONES = '1;
   localparam logic [KEY_W-1:0] KEY_MARK = 64'h8000_0000_0000_0001;
   localparam logic [KEY_W-1:0] KEY_TAG  = 64'hA5A5_5A5A_C3C3_3C3C;
   localparam int RANDOM_PER_PHASE = 350;
   localparam int DRAIN_CYCLES = NODES + 20;

   typedef struct packed {
      status_type          status;
      logic [IDX_W-1:0]    index;
      logic [KEY_W-1:0]    key;
      logic [COUNT_W-1:0]  count;
   } list_reply_type;

   typedef struct packed {
      logic [CMD_W-1:0]  cmd;
      logic [IDX_W-1:0]  idx;
      logic [KEY_W-1:0]  key;
      int                reps;
      bit                typed;
      list_reply_type    want;
   } stim_row_type;

   localparam int PLAN_ROWS = 25;
   localparam stim_row_type PLAN [PLAN_ROWS] = '{
      '{CMD_READ,     6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd0}},
      '{CMD_FIND,     6'd0,  64'd0,    1,  1'b1, '{ST_MISS, 6'd0,  64'd0,    7'd0}},
      '{CMD_REMOVE,   6'd0,  64'd0,    1,  1'b1, '{ST_MISS, 6'd0,  64'd0,    7'd0}},
      '{CMD_APPEND,   6'd0,  KEY_ONES, 1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd1}},
      '{CMD_APPEND,   6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd1,  64'd0,    7'd2}},
      '{CMD_FIND,     6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd1,  64'd0,    7'd2}},
      '{CMD_WRITE,    6'd63, KEY_MARK, 1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd2}},
      '{CMD_READ,     6'd63, 64'd0,    1,  1'b1, '{ST_OK,   6'd0,  KEY_MARK, 7'd2}},
      '{CMD_REMOVE,   6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd1}},
      '{CMD_REMOVE,   6'd0,  64'd0,    1,  1'b1, '{ST_MISS, 6'd0,  64'd0,    7'd1}},
      '{CMD_APPEND,   6'd0,  64'd5,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd2}},
      '{CMD_REMOVE,   6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd1}},
      '{CMD_SPARE_LO, 6'd63, KEY_ONES, 1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd1}},
      '{CMD_SPARE_HI, 6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd1}},
      '{CMD_CLEAR,    6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd0}},
      '{CMD_FIND,     6'd0,  KEY_ONES, 1,  1'b1, '{ST_MISS, 6'd0,  64'd0,    7'd0}},
      '{CMD_READ,     6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd5,    7'd0}},
      '{CMD_APPEND,   6'd0,  64'd0,    64, 1'b0, '{ST_OK,   6'd0,  64'd0,    7'd0}},
      '{CMD_APPEND,   6'd0,  64'd1,    1,  1'b1, '{ST_FULL, 6'd0,  64'd0,    7'd64}},
      '{CMD_WRITE,    6'd63, KEY_TAG,  1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd64}},
      '{CMD_FIND,     6'd0,  KEY_TAG,  1,  1'b0, '{ST_OK,   6'd0,  64'd0,    7'd0}},
      '{CMD_REMOVE,   6'd63, 64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd63}},
      '{CMD_REMOVE,   6'd31, 64'd0,    1,  1'b1, '{ST_OK,   6'd0,  64'd0,    7'd62}},
      '{CMD_APPEND,   6'd0,  64'd0,    1,  1'b1, '{ST_OK,   6'd31, 64'd0,    7'd63}},
      '{CMD_FIND,     6'd0,  64'd0,    1,  1'b0, '{ST_OK,   6'd0,  64'd0,    7'd0}}
   };

   logic clock;
   logic reset;

   alfl_req_if req_bus ();
   alfl_rsp_if rsp_bus ();

   array_linked_list_with_free_list_core #(.DEPTH(DEPTH_DEF)) dut (
      .clock (clock),
      .reset (reset),
      .req   (req_bus),
      .rsp   (rsp_bus)
   );

   logic [KEY_W-1:0]   key_mem  [NODES];
   logic [COUNT_W-1:0] next_ptr [NODES];
   logic [COUNT_W-1:0] head_ptr;
   logic [COUNT_W-1:0] free_ptr;
   logic [COUNT_W-1:0] live_n;

   list_reply_type expected_replies [$];
   list_reply_type oldest;

   int req_idle_pct;
   int rsp_stall_pct;
   int errors;
   int beats_sent;
   int replies_checked;
   int full_hits;
   int find_hits;
   int removes_done;
   int clears_done;

   function automatic void rebuild_chain();
      for (int i = 0; i < NODES; i++) begin
         next_ptr[i] = (i == NODES - 1) ? NIL : COUNT_W'(i + 1);
      end
      free_ptr = '0;
      head_ptr = NIL;
      live_n   = '0;
   endfunction

   function automatic list_reply_type apply_command(logic [CMD_W-1:0] cmd,
                                                    logic [IDX_W-1:0] idx,
                                                    logic [KEY_W-1:0] key);
      list_reply_type r;
      int p;
      int node;
      bit hit;
      r = '{ST_OK, '0, '0, '0};
      case (cmd)
         CMD_APPEND: begin
            if (free_ptr >= NODES) begin
               r.status = ST_FULL;
               full_hits++;
            end else begin
               node = free_ptr;
               free_ptr = next_ptr[node];
               key_mem[node] = key;
               next_ptr[node] = NIL;
               if (head_ptr >= NODES) begin
                  head_ptr = COUNT_W'(node);
               end else begin
                  p = head_ptr;
                  for (int s = 0; s < NODES && next_ptr[p] < NODES; s++) p = next_ptr[p];
                  next_ptr[p] = COUNT_W'(node);
               end
               live_n++;
               r.index = IDX_W'(node);
            end
         end
         CMD_FIND: begin
            r.status = ST_MISS;
            p = head_ptr;
            for (int s = 0; s < NODES && p < NODES; s++) begin
               if (key_mem[p] == key) begin
                  r.status = ST_OK;
                  r.index = IDX_W'(p);
                  find_hits++;
                  break;
               end
               p = next_ptr[p];
            end
         end
         CMD_REMOVE: begin
            if (head_ptr >= NODES || idx >= NODES) begin
               r.status = ST_MISS;
            end else if (head_ptr == idx) begin
               head_ptr = next_ptr[idx];
               next_ptr[idx] = free_ptr;
               free_ptr = COUNT_W'(idx);
               live_n--;
               removes_done++;
            end else begin
               hit = 1'b0;
               p = head_ptr;
               for (int s = 0; s < NODES && p < NODES; s++) begin
                  if (next_ptr[p] == idx) begin
                     hit = 1'b1;
                     break;
                  end
                  p = next_ptr[p];
               end
               if (!hit) begin
                  r.status = ST_MISS;
               end else begin
                  next_ptr[p] = next_ptr[idx];
                  next_ptr[idx] = free_ptr;
                  free_ptr = COUNT_W'(idx);
                  live_n--;
                  removes_done++;
               end
            end
         end
         CMD_READ: begin
            if (idx < NODES) r.key = key_mem[idx];
            else r.status = ST_MISS;
         end
         CMD_WRITE: begin
            if (idx < NODES) key_mem[idx] = key;
            else r.status = ST_MISS;
         end
         CMD_CLEAR: begin
            rebuild_chain();
            clears_done++;
         end
         default: ;
      endcase
      r.count = live_n;
      return r;
   endfunction

   function automatic logic [IDX_W-1:0] pick_live_node();
      int p;
      int k;
      p = head_ptr;
      k = $urandom_range(int'(live_n) - 1);
      repeat (k) p = next_ptr[p];
      return IDX_W'(p);
   endfunction

   function automatic logic [KEY_W-1:0] random_key();
      if ($urandom_range(9) < 3) return KEY_W'($urandom_range(7));
      return {$urandom, $urandom};
   endfunction

   task automatic send_beat(input logic [CMD_W-1:0] cmd, input logic [IDX_W-1:0] idx,
                            input logic [KEY_W-1:0] key, input bit typed,
                            input list_reply_type want);
      list_reply_type r;
      @(negedge clock);
      while ($urandom_range(99) < req_idle_pct) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid      = 1'b1;
      req_bus.command    = cmd;
      req_bus.slot_index = idx;
      req_bus.entry_key  = key;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      r = apply_command(cmd, idx, key);
      expected_replies.insert(expected_replies.size(), typed ? want : r);
      beats_sent++;
   endtask

   task automatic check_field(input string name, input logic [KEY_W-1:0] want,
                              input logic [KEY_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $realtime, name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
         if (expected_replies.size() == 0) begin
            $display("%0t: unexpected result beat, expected none, actual status %0h count %0d",
                     $realtime, rsp_bus.status, rsp_bus.entry_count);
            errors++;
         end else begin
            oldest = expected_replies.pop_front();
            check_field("status", KEY_W'(oldest.status), KEY_W'(rsp_bus.status));
            check_field("result_index", KEY_W'(oldest.index), KEY_W'(rsp_bus.result_index));
            check_field("read_key", oldest.key, rsp_bus.read_key);
            check_field("entry_count", KEY_W'(oldest.count), KEY_W'(rsp_bus.entry_count));
            replies_checked++;
         end
      end
   end

   always @(negedge clock) begin
      rsp_bus.ready = ($urandom_range(99) >= rsp_stall_pct);
   end

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #15ms;
      $display("RESULT: ERROR");
      $finish;
   end

   initial begin
      logic [CMD_W-1:0] cmd;
      logic [IDX_W-1:0] idx;
      logic [KEY_W-1:0] key;
      int roll;
      int grow_pct;
      reset              = 1'b1;
      req_bus.valid      = 1'b0;
      req_bus.command    = CMD_APPEND;
      req_bus.slot_index = '0;
      req_bus.entry_key  = '0;
      req_idle_pct       = 0;
      rsp_stall_pct      = 0;
      errors             = 0;
      beats_sent         = 0;
      replies_checked    = 0;
      full_hits          = 0;
      find_hits          = 0;
      removes_done       = 0;
      clears_done        = 0;
      grow_pct           = 450;
      for (int i = 0; i < NODES; i++) key_mem[i] = '0;
      rebuild_chain();
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < PLAN_ROWS; r++) begin
         for (int n = 0; n < PLAN[r].reps; n++) begin
            send_beat(PLAN[r].cmd, PLAN[r].idx,
                      (PLAN[r].reps > 1) ? random_key() : PLAN[r].key,
                      PLAN[r].typed, PLAN[r].want);
         end
      end

      for (int ph = 0; ph < 4; ph++) begin
         req_idle_pct  = (ph == 1) ? 51 : (ph == 3) ? 22 : 0;
         rsp_stall_pct = (ph == 2) ? 51 : (ph == 3) ? 22 : 0;
         for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
            if (n % 150 == 0) grow_pct = $urandom_range(1) ? 450 : 150;
            roll = $urandom_range(999);
            idx  = IDX_W'($urandom_range(NODES - 1));
            key  = random_key();
            if (roll < grow_pct) begin
               cmd = CMD_APPEND;
            end else if (roll < 550) begin
               cmd = CMD_REMOVE;
               if (live_n != 0 && $urandom_range(3) != 0) idx = pick_live_node();
            end else if (roll < 800) begin
               cmd = CMD_FIND;
               roll = $urandom_range(99);
               if (live_n != 0 && roll < 60) key = key_mem[pick_live_node()];
               else if (roll < 75) key = key_mem[idx];
            end else if (roll < 880) begin
               cmd = CMD_READ;
            end else if (roll < 975) begin
               cmd = CMD_WRITE;
            end else if (roll < 978) begin
               cmd = CMD_CLEAR;
            end else if (roll < 989) begin
               cmd = $urandom_range(1) ? CMD_SPARE_HI : CMD_SPARE_LO;
            end else begin
               cmd = CMD_FIND;
            end
            send_beat(cmd, idx, key, 1'b0, '0);
         end
      end

      @(negedge clock);
      req_bus.valid = 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d commands, checked %0d results; %0d appends hit a full store,",
               beats_sent, replies_checked, full_hits);
      $display("%0d finds matched, %0d nodes removed, %0d clears.",
               find_hits, removes_done, clears_done);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule

// ===== sim.f =====
src/alfl_pkg.sv
src/alfl_req_if.sv
src/alfl_rsp_if.sv
src/alfl_ram.sv
src/array_linked_list_with_free_list_core.sv
verif/tb_top.sv
